FILE: rtl/lda_gibbs_token_resample_top_assert.svh
// ----------------------------------------------------------------------------
// lda_gibbs_token_resample_top_assert.svh
// Assertion macros for the token resampler.
// ----------------------------------------------------------------------------
`ifndef LDA_GIBBS_TOKEN_RESAMPLE_TOP_ASSERT_SVH
`define LDA_GIBBS_TOKEN_RESAMPLE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LGR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LGR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LGR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LGR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/lgr_pkg.sv
// ----------------------------------------------------------------------------
// lgr_pkg
// Shared types and constants of the token resampler.
// ----------------------------------------------------------------------------
package lgr_pkg;
   localparam int TOPIC_W  = 7;
   localparam int DOC_W    = 8;
   localparam int WORD_W   = 10;
   localparam int CNT_W    = 24;
   localparam int DCNT_W   = 16;
   localparam int WGT_W    = 48;
   localparam int Q_W      = 32;
   localparam int MAX_TOPICS = 1 << TOPIC_W;
   localparam int OPA_W    = Q_W + 1;             // doc term
   localparam int OPB_W    = CNT_W + 16 + 1;      // word term / divisor
   localparam int PROD_W   = WGT_W + OPA_W;       // serial product
   localparam int NUM_W    = OPA_W + OPB_W;       // dividend
   localparam int CSR_IDX_W = 8;

   typedef enum logic [1:0] {
      OP_LOAD_WORD  = 2'd0,
      OP_LOAD_TOTAL = 2'd1,
      OP_LOAD_DOC   = 2'd2,
      OP_RESAMPLE   = 2'd3
   } lgr_op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TOPICS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOCAB_BETA = 8'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DEC_RD, ST_DEC_WR, ST_W_RD, ST_W_MUL, ST_W_MULW, ST_W_DIVW,
      ST_U_MUL, ST_U_WAIT, ST_S_RD, ST_S_CMP, ST_INC_RD, ST_INC_WR
   } lgr_state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } lgr_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lgr_stat_type;
endpackage

FILE: rtl/lda_gibbs_token_resample_top.sv
// ----------------------------------------------------------------------------
// lda_gibbs_token_resample_top
// Collapsed Gibbs topic resampler for one token, fixed point Q16.16.
// ----------------------------------------------------------------------------
// Loads (op 0..2) complete while idle and busy stays low. A resample holds
// busy until its result strobe, visiting each active topic in turn: each
// topic's weight goes through
// one bit-serial multiplier/divider, one bit per cycle, which also forms the
// scaled random value. The result strobe rsp_valid is high for one cycle
// with the sampled topic and total weight; the receiver cannot stall it.
// Count stores are not cleared; entries must be loaded before use.
`include "lda_gibbs_token_resample_top_assert.svh"

module lda_gibbs_token_resample_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_op,
   input  logic [lgr_pkg::DOC_W-1:0]       req_doc_index,
   input  logic [lgr_pkg::WORD_W-1:0]      req_word_id,
   input  logic [lgr_pkg::TOPIC_W-1:0]     req_topic_id,
   input  logic [lgr_pkg::CNT_W-1:0]       req_count_value,
   input  logic [lgr_pkg::Q_W-1:0]         req_random_fraction,
   output logic                            rsp_valid,
   output logic [lgr_pkg::TOPIC_W-1:0]     rsp_new_topic,
   output logic [lgr_pkg::WGT_W-1:0]       rsp_total_weight,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lgr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lgr_pkg::Q_W-1:0]         csr_wdata
);
   import lgr_pkg::*;

   localparam int WT_AW = WORD_W + TOPIC_W;
   localparam int DT_AW = DOC_W + TOPIC_W;

   lgr_state_type      state_ff, state_in;
   logic [7:0]         num_topics_ff;
   logic [Q_W-1:0]     alpha_ff, beta_ff, vbeta_ff;
   logic [DOC_W-1:0]   doc_ff, doc_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [TOPIC_W-1:0] topic_ff, topic_in, k_ff, k_in, last_ff, last_in;
   logic [Q_W-1:0]     frac_ff, frac_in;
   logic [WGT_W-1:0]   sum_ff, sum_in, u_ff, u_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOPIC_W-1:0] rsp_topic_ff, rsp_topic_in;
   logic [WGT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic               accept;
   logic               wt_we, tt_we, dt_we, rw_we;
   logic [WT_AW-1:0]   wt_waddr, wt_raddr;
   logic [DT_AW-1:0]   dt_waddr, dt_raddr;
   logic [DCNT_W-1:0]  dt_wdata, dt_q;
   logic [CNT_W-1:0]   wt_q, tt_q;
   logic [WGT_W-1:0]   rw_q;

   lgr_ctrl_type       u_ctrl;
   lgr_stat_type       u_stat;
   logic [WGT_W-1:0]   mul_a, quotient;
   logic [OPA_W-1:0]   mul_b, term_a;
   logic [OPB_W-1:0]   term_b, term_d;
   logic [PROD_W-1:0]  product;
   logic [Q_W-1:0]     vb;
   logic [WGT_W:0]     sum_wide;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         num_topics_ff <= 8'd100;
         alpha_ff      <= 32'd6554;
         beta_ff       <= 32'd6554;
         vbeta_ff      <= 32'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_TOPICS: num_topics_ff <= csr_wdata[7:0];
            CSR_ALPHA:      alpha_ff      <= csr_wdata;
            CSR_BETA:       beta_ff       <= csr_wdata;
            CSR_VOCAB_BETA: vbeta_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- stores ----
   lgr_ram #(.WIDTH(CNT_W), .DEPTH(1 << WT_AW)) u_word_topic (
      .clock(clock), .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(req_count_value),
      .rd_addr(wt_raddr), .rd_data(wt_q));

   lgr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TOPICS)) u_topic_total (
      .clock(clock), .wr_en(tt_we), .wr_addr(req_topic_id), .wr_data(req_count_value),
      .rd_addr(k_ff), .rd_data(tt_q));

   lgr_ram #(.WIDTH(DCNT_W), .DEPTH(1 << DT_AW)) u_doc_topic (
      .clock(clock), .wr_en(dt_we), .wr_addr(dt_waddr), .wr_data(dt_wdata),
      .rd_addr(dt_raddr), .rd_data(dt_q));

   lgr_ram #(.WIDTH(WGT_W), .DEPTH(MAX_TOPICS)) u_running (
      .clock(clock), .wr_en(rw_we), .wr_addr(k_ff), .wr_data(sum_in),
      .rd_addr(k_ff), .rd_data(rw_q));

   assign wt_waddr = {req_word_id, req_topic_id};
   assign wt_raddr = {word_ff, k_ff};
   assign wt_we    = accept && (req_op == OP_LOAD_WORD);
   assign tt_we    = accept && (req_op == OP_LOAD_TOTAL);

   // ---- shared serial unit ----
   lgr_muldiv u_muldiv (
      .clock(clock), .reset(reset), .ctrl(u_ctrl), .mul_a(mul_a), .mul_b(mul_b),
      .div_num(product[NUM_W-1:0]), .div_den(term_d), .stat(u_stat),
      .product(product), .quotient(quotient));

   always_comb begin
      vb     = (vbeta_ff == '0) ? Q_W'(1) : vbeta_ff;
      term_a = {1'b0, dt_q, 16'h0} + {1'b0, alpha_ff};
      term_b = {1'b0, wt_q, 16'h0} + {9'h0, beta_ff};
      term_d = {1'b0, tt_q, 16'h0} + {9'h0, vb};
      sum_wide = {1'b0, sum_ff} + {1'b0, quotient};
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      doc_ff       <= doc_in;
      word_ff      <= word_in;
      topic_ff     <= topic_in;
      k_ff         <= k_in;
      last_ff      <= last_in;
      frac_ff      <= frac_in;
      sum_ff       <= sum_in;
      u_ff         <= u_in;
      rsp_topic_ff <= rsp_topic_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_comb begin
      state_in = state_ff;
      doc_in = doc_ff;   word_in = word_ff;  topic_in = topic_ff;
      k_in = k_ff;       last_in = last_ff;  frac_in = frac_ff;
      sum_in = sum_ff;   u_in = u_ff;
      rsp_valid_in = 1'b0;
      rsp_topic_in = rsp_topic_ff;
      rsp_total_in = rsp_total_ff;
      u_ctrl   = '0;
      mul_a    = {7'h0, term_b};
      mul_b    = term_a;
      rw_we    = 1'b0;
      dt_we    = 1'b0;
      dt_waddr = {doc_ff, topic_ff};
      dt_wdata = dt_q;
      dt_raddr = {doc_ff, topic_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_LOAD_DOC)) begin
               dt_we    = 1'b1;
               dt_waddr = {req_doc_index, req_topic_id};
               dt_wdata = (req_count_value > CNT_W'(16'hFFFF)) ? 16'hFFFF
                                                               : req_count_value[15:0];
            end
            if (accept && (req_op == OP_RESAMPLE)) begin
               doc_in   = req_doc_index;
               word_in  = req_word_id;
               topic_in = req_topic_id;
               frac_in  = req_random_fraction;
               sum_in   = '0;
               k_in     = '0;
               if (num_topics_ff == 8'd0) begin
                  last_in = '0;
               end else if (num_topics_ff >= 8'(MAX_TOPICS)) begin
                  last_in = TOPIC_W'(MAX_TOPICS - 1);
               end else begin
                  last_in = TOPIC_W'(num_topics_ff - 8'd1);
               end
               state_in = ST_DEC_RD;
            end
         end
         ST_DEC_RD: state_in = ST_DEC_WR;
         ST_DEC_WR: begin
            dt_we    = 1'b1;
            dt_wdata = (dt_q != '0) ? dt_q - 16'd1 : dt_q;
            state_in = ST_W_RD;
         end
         ST_W_RD: begin
            dt_raddr = {doc_ff, k_ff};
            state_in = ST_W_MUL;
         end
         ST_W_MUL: begin
            dt_raddr     = {doc_ff, k_ff};
            u_ctrl.start = 1'b1;
            state_in     = ST_W_MULW;
         end
         ST_W_MULW: begin
            dt_raddr = {doc_ff, k_ff};
            if (u_stat.done) begin
               u_ctrl.start  = 1'b1;
               u_ctrl.is_div = 1'b1;
               state_in      = ST_W_DIVW;
            end
         end
         ST_W_DIVW: begin
            dt_raddr = {doc_ff, k_ff};
            if (u_stat.done) begin
               sum_in = sum_wide[WGT_W] ? '1 : sum_wide[WGT_W-1:0];
               rw_we  = 1'b1;
               if (k_ff == last_ff) begin
                  state_in = ST_U_MUL;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_W_RD;
               end
            end
         end
         ST_U_MUL: begin
            mul_a        = sum_ff;
            mul_b        = {1'b0, frac_ff};
            u_ctrl.start = 1'b1;
            state_in     = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            if (u_stat.done) begin
               u_in     = product[WGT_W+Q_W-1:Q_W];
               k_in     = '0;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: state_in = ST_S_CMP;
         ST_S_CMP: begin
            if ((rw_q >= u_ff) || (k_ff == last_ff)) begin
               topic_in = k_ff;
               state_in = ST_INC_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_INC_RD: state_in = ST_INC_WR;
         ST_INC_WR: begin
            dt_we        = 1'b1;
            dt_wdata     = (dt_q != 16'hFFFF) ? dt_q + 16'd1 : dt_q;
            rsp_valid_in = 1'b1;
            rsp_topic_in = topic_ff;
            rsp_total_in = sum_ff;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_topic    = rsp_topic_ff;
   assign rsp_total_weight = rsp_total_ff;

   `LGR_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "result word while busy")
   `LGR_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "repeated result word")
   `LGR_ASSERT_IMP(a_unit_free, clock, reset, u_ctrl.start, !u_stat.busy, "unit started while busy")
   `LGR_ASSERT_IMP(a_topic_range, clock, reset, rsp_valid, rsp_new_topic <= last_ff, "topic beyond active range")
endmodule

FILE: rtl/lgr_ram.sv
// ----------------------------------------------------------------------------
// lgr_ram
// Generic simple dual-port RAM, registered read.
// ----------------------------------------------------------------------------
module lgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/lgr_muldiv.sv
// ----------------------------------------------------------------------------
// lgr_muldiv
// Bit-serial shift-add multiplier and restoring divider with 48-bit
// saturating quotient. One bit per cycle.
// ----------------------------------------------------------------------------
module lgr_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  lgr_pkg::lgr_ctrl_type      ctrl,
   input  logic [lgr_pkg::WGT_W-1:0]  mul_a,
   input  logic [lgr_pkg::OPA_W-1:0]  mul_b,
   input  logic [lgr_pkg::NUM_W-1:0]  div_num,
   input  logic [lgr_pkg::OPB_W-1:0]  div_den,
   output lgr_pkg::lgr_stat_type      stat,
   output logic [lgr_pkg::PROD_W-1:0] product,
   output logic [lgr_pkg::WGT_W-1:0]  quotient
);
   import lgr_pkg::*;

   logic             busy_ff, busy_in, done_ff, done_in, is_div_ff, is_div_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [WGT_W-1:0] a_ff, a_in, hi_ff, hi_in;
   logic [OPA_W-1:0] lo_ff, lo_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [OPB_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [WGT_W-1:0] quo_ff, quo_in;
   logic             ovf_ff, ovf_in;
   logic [WGT_W:0]   msum;
   logic [OPB_W:0]   r2;
   logic             ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      a_ff      <= a_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      ovf_ff    <= ovf_in;
   end

   always_comb begin
      msum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      r2   = {rem_ff, num_ff[NUM_W-1]};
      ge   = r2 >= {1'b0, den_ff};

      busy_in = busy_ff;  done_in = 1'b0;  is_div_in = is_div_ff;
      cnt_in = cnt_ff;    a_in = a_ff;     hi_in = hi_ff;  lo_in = lo_ff;
      num_in = num_ff;    den_in = den_ff; rem_in = rem_ff;
      quo_in = quo_ff;    ovf_in = ovf_ff;

      if (!busy_ff) begin
         if (ctrl.start) begin
            busy_in   = 1'b1;
            is_div_in = ctrl.is_div;
            cnt_in    = ctrl.is_div ? 7'(NUM_W - 1) : 7'(OPA_W - 1);
            a_in      = mul_a;
            hi_in     = '0;
            lo_in     = mul_b;
            num_in    = div_num;
            den_in    = div_den;
            rem_in    = '0;
            quo_in    = '0;
            ovf_in    = 1'b0;
         end
      end else begin
         if (is_div_ff) begin
            rem_in = ge ? OPB_W'(r2 - {1'b0, den_ff}) : r2[OPB_W-1:0];
            quo_in = {quo_ff[WGT_W-2:0], ge};
            ovf_in = ovf_ff | quo_ff[WGT_W-1];   // a set bit shifted out
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end else begin
            hi_in = msum[WGT_W:1];
            lo_in = {msum[0], lo_ff[OPA_W-1:1]};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = {hi_ff, lo_ff};
   assign quotient  = ovf_ff ? '1 : quo_ff;
endmodule

FILE: test/lda_gibbs_token_resample_top_tb.sv
// ----------------------------------------------------------------------------
// lda_gibbs_token_resample_top_tb
// Self-checking bench for the token resampler: loads the count stores, runs
// resamples over several register settings and checks each result word
// against a bit-accurate topic sampler kept inside the bench.
// ----------------------------------------------------------------------------
module lda_gibbs_token_resample_top_tb;
   import lgr_pkg::*;

   localparam int  NDOC = 256;
   localparam int  NWORD = 1024;
   localparam int  NTOP = 128;
   localparam longint CYCLE_LIMIT = 6000000;
   localparam logic [47:0] W_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      lgr_op_type  op;
      logic [7:0]  doc;
      logic [9:0]  word;
      logic [6:0]  topic;
      logic [23:0] count;
      logic [31:0] frac;
   } token_word_t;

   typedef struct packed {
      logic [6:0]  topic;
      logic [47:0] total;
   } sample_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   token_word_t cur_word = '0;
   logic rsp_valid;
   logic [6:0] rsp_new_topic;
   logic [47:0] rsp_total_weight;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   lda_gibbs_token_resample_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(cur_word.op), .req_doc_index(cur_word.doc), .req_word_id(cur_word.word),
      .req_topic_id(cur_word.topic), .req_count_value(cur_word.count),
      .req_random_fraction(cur_word.frac),
      .rsp_valid(rsp_valid), .rsp_new_topic(rsp_new_topic),
      .rsp_total_weight(rsp_total_weight),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sampler state, updated at acceptance
   logic [23:0] wt_cnt [NWORD*NTOP];
   logic [23:0] tot_cnt [NTOP];
   logic [15:0] dt_cnt [NDOC*NTOP];
   logic [7:0]  m_topics = 8'd100;
   logic [31:0] m_alpha = 32'd6554;
   logic [31:0] m_beta = 32'd6554;
   logic [31:0] m_vbeta = 32'd65536;

   // stimulus side bookkeeping: which entries have been loaded
   bit wt_ok [NWORD*NTOP];
   bit tot_ok [NTOP];
   bit dt_ok [NDOC*NTOP];
   int gen_k;

   token_word_t pending_words[$];
   sample_t     sample_expect_q[$];
   int errors = 0;
   bit taken = 0;
   int gap_left = 0;
   int burst_left = 0;
   longint cycles = 0;

   task automatic resample_predict(input token_word_t w);
      int kk, chosen, db, wb;
      logic [47:0] run [NTOP];
      logic [63:0] a, b, d, vb;
      logic [127:0] q, sum, u;
      sample_t s;
      begin
         db = int'(w.doc) * NTOP;
         wb = int'(w.word) * NTOP;
         case (w.op)
            OP_LOAD_WORD:  wt_cnt[wb + w.topic] = w.count;
            OP_LOAD_TOTAL: tot_cnt[w.topic] = w.count;
            OP_LOAD_DOC:   dt_cnt[db + w.topic] = (w.count > 24'hFFFF) ? 16'hFFFF
                                                                       : w.count[15:0];
            default: begin
               kk = (m_topics == 0) ? 1 : ((m_topics > NTOP) ? NTOP : int'(m_topics));
               vb = (m_vbeta == 0) ? 64'd1 : 64'(m_vbeta);
               if (dt_cnt[db + w.topic] > 0) dt_cnt[db + w.topic] -= 16'd1;
               sum = 0;
               for (int k = 0; k < kk; k++) begin
                  a = (64'(dt_cnt[db + k]) << 16) + 64'(m_alpha);
                  b = (64'(wt_cnt[wb + k]) << 16) + 64'(m_beta);
                  d = (64'(tot_cnt[k]) << 16) + vb;
                  q = (128'(a) * 128'(b)) / 128'(d);
                  if (q > 128'(W_MAX)) q = 128'(W_MAX);
                  sum = sum + q;
                  if (sum > 128'(W_MAX)) sum = 128'(W_MAX);
                  run[k] = sum[47:0];
               end
               u = (128'(w.frac) * sum) >> 32;
               chosen = kk - 1;
               for (int k = kk - 1; k >= 0; k--)
                  if (128'(run[k]) >= u) chosen = k;
               if (dt_cnt[db + chosen] < 16'hFFFF) dt_cnt[db + chosen] += 16'd1;
               s = '{topic: 7'(chosen), total: sum[47:0]};
               sample_expect_q.insert(sample_expect_q.size(), s);
            end
         endcase
      end
   endtask

   // acceptance and result check
   always @(posedge clock) begin
      sample_t e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      taken = !reset && start && !busy;
      if (taken) resample_predict(cur_word);
      if (!reset && rsp_valid) begin
         if (sample_expect_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word topic %0d total %h", $time,
                     rsp_new_topic, rsp_total_weight);
         end else begin
            e = sample_expect_q.pop_front();
            if (e.topic !== rsp_new_topic) begin
               errors++;
               $display("%0t: new_topic expected %0d actual %0d", $time, e.topic,
                        rsp_new_topic);
            end
            if (e.total !== rsp_total_weight) begin
               errors++;
               $display("%0t: total_weight expected %h actual %h", $time, e.total,
                        rsp_total_weight);
            end
         end
      end
   end

   // driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            cur_word <= pending_words.pop_front();
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic logic [23:0] rand_count();
      case ($urandom_range(0, 7))
         0: return 24'hFFFFFF;
         1: return 24'h0;
         2: return 24'($urandom);
         3: return 24'($urandom_range(65530, 65545));
         default: return 24'($urandom_range(0, 60));
      endcase
   endfunction

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h40000);
      endcase
   endfunction

   task automatic add_load(input lgr_op_type op, input int doc, input int word, input int topic,
                           input logic [23:0] cnt);
      token_word_t w;
      begin
         w = '{op: op, doc: 8'(doc), word: 10'(word), topic: 7'(topic), count: cnt,
               frac: $urandom};
         case (op)
            OP_LOAD_WORD:  wt_ok[word * NTOP + topic] = 1;
            OP_LOAD_TOTAL: tot_ok[topic] = 1;
            default:       dt_ok[doc * NTOP + topic] = 1;
         endcase
         pending_words.insert(pending_words.size(), w);
      end
   endtask

   // loads whatever a resample would read that has never been written
   task automatic add_resample(input int doc, input int word, input int topic,
                               input logic [31:0] frac);
      token_word_t w;
      begin
         for (int k = 0; k < gen_k; k++) begin
            if (!dt_ok[doc * NTOP + k]) add_load(OP_LOAD_DOC, doc, $urandom, k, rand_count());
            if (!wt_ok[word * NTOP + k]) add_load(OP_LOAD_WORD, $urandom, word, k, rand_count());
            if (!tot_ok[k]) add_load(OP_LOAD_TOTAL, $urandom, $urandom, k, rand_count());
         end
         if (!dt_ok[doc * NTOP + topic])
            add_load(OP_LOAD_DOC, doc, $urandom, topic, rand_count());
         w = '{op: OP_RESAMPLE, doc: 8'(doc), word: 10'(word), topic: 7'(topic),
               count: 24'($urandom), frac: frac};
         pending_words.insert(pending_words.size(), w);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            CSR_NUM_TOPICS: m_topics = data[7:0];
            CSR_ALPHA:      m_alpha = data;
            CSR_BETA:       m_beta = data;
            default:        m_vbeta = data;
         endcase
         @(negedge clock);
         csr_valid <= 1'b0;
      end
   endtask

   task automatic drain();
      begin
         while (pending_words.size() > 0 || start || sample_expect_q.size() > 0)
            @(posedge clock);
         repeat (40) @(posedge clock);
         while (busy) @(posedge clock);
      end
   endtask

   task automatic set_config(input logic [7:0] k, input logic [31:0] al, input logic [31:0] be,
                             input logic [31:0] vb);
      begin
         drain();
         csr_write(CSR_NUM_TOPICS, 32'(k));
         csr_write(CSR_ALPHA, al);
         csr_write(CSR_BETA, be);
         csr_write(CSR_VOCAB_BETA, vb);
         gen_k = (k == 0) ? 1 : ((k > NTOP) ? NTOP : int'(k));
      end
   endtask

   int docs [4];
   int words [4];
   int sel;

   initial begin
      gen_k = 100;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, frac extremes
      add_resample(0, 0, 0, 32'h0);
      add_resample(0, 0, 99, 32'hFFFF_FFFF);
      add_resample(255, 1023, 127, $urandom);
      // all topics, largest priors, zero vocab_beta
      set_config(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      add_resample(255, 1023, 127, 32'h8000_0000);
      add_load(OP_LOAD_DOC, 7, 5, 3, 24'hFFFFFF);
      add_resample(7, 5, 3, $urandom);
      // one topic, zero priors, doc counts loaded as zero
      set_config(8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      add_load(OP_LOAD_DOC, 9, 0, 0, 24'h0);
      add_resample(9, 3, 0, 32'hFFFF_FFFF);
      add_load(OP_LOAD_DOC, 9, 0, 100, 24'h0);
      add_resample(9, 3, 100, 32'h1234_5678);

      // random phases, small topic counts
      for (int ph = 0; ph < 12; ph++) begin
         set_config(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 8)),
                    rand_q(), rand_q(),
                    ($urandom_range(0, 5) == 0) ? 32'd1 : rand_q());
         foreach (docs[i]) docs[i] = $urandom_range(0, NDOC - 1);
         foreach (words[i]) words[i] = $urandom_range(0, NWORD - 1);
         for (int n = 0; n < 30; n++) begin
            sel = $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 55)
               add_resample(docs[sel], words[sel],
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(0, gen_k - 1),
                            ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom);
            else
               add_load(lgr_op_type'($urandom_range(0, 2)),
                        ($urandom_range(0, 1) == 0) ? docs[sel] : $urandom_range(0, 255),
                        ($urandom_range(0, 1) == 0) ? words[sel] : $urandom_range(0, 1023),
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, gen_k - 1)
                                                    : $urandom_range(0, 127),
                        rand_count());
         end
      end
      drain();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
